FILE: rtl/fmr_pkg.sv
// shared types, codes and helper functions of the framed message receiver
`timescale 1ns / 1ps
`default_nettype none

package fmr_pkg;

    // number of remembered check keys
    localparam int NUM_CHECK_KEYS = 3;
    localparam int KEY_IDX_W      = (NUM_CHECK_KEYS > 1) ? $clog2(NUM_CHECK_KEYS) : 1;

    // header length in bytes
    localparam logic [31:0] HDR_BYTES = 32'd12;

    // result event codes
    localparam logic [2:0] EV_NONE         = 3'd0;
    localparam logic [2:0] EV_BEGIN        = 3'd1;
    localparam logic [2:0] EV_PAYLOAD      = 3'd2;
    localparam logic [2:0] EV_LAST_GOOD    = 3'd3;
    localparam logic [2:0] EV_REPLY        = 3'd4;
    localparam logic [2:0] EV_CLOSE_OK     = 3'd5;
    localparam logic [2:0] EV_CLOSE_ABNORM = 3'd6;
    localparam logic [2:0] EV_ERROR        = 3'd7;

    // error codes
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_CHECKSUM   = 3'd1;
    localparam logic [2:0] ERR_UNKNOWN    = 3'd2;
    localparam logic [2:0] ERR_LENGTH     = 3'd3;
    localparam logic [2:0] ERR_CHECK_ID   = 3'd4;
    localparam logic [2:0] ERR_UNEXPECTED = 3'd5;

    // input function codes
    localparam logic FUNC_BYTE  = 1'b0;
    localparam logic FUNC_CLOSE = 1'b1;

    // one received item
    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
    } t_in_item;

    // one result item
    typedef struct packed {
        logic [2:0]  event_res;
        logic [2:0]  error_code;
        logic [7:0]  payload_byte;
        logic [31:0] job_id;
        logic [31:0] reply_word;
    } t_result;

    // payload checksum step: xor then rotate left by one
    function automatic logic [31:0] sum_step(input logic [31:0] a, input logic [7:0] b);
        logic [31:0] x;
        x = a ^ {24'd0, b};
        return {x[30:0], a[31]};
    endfunction

    // session key update
    function automatic logic [31:0] roll_key(input logic [31:0] k);
        return k ^ (k << 3) ^ (k >> 7) ^ (k << 17) ^ (k >> 27);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/fmr_in_stage.sv
// input register stage that holds one received item until the step logic takes it
`timescale 1ns / 1ps
`default_nettype none

module fmr_in_stage (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  wire                i_func,
    input  wire  [7:0]         i_data_byte,
    input  wire                i_res_ready,
    output logic               o_item_valid,
    output fmr_pkg::t_in_item  o_item
);

    logic              r_valid;
    logic              n_valid;
    fmr_pkg::t_in_item r_item;
    logic              w_take;
    logic              w_load;

    // the held item moves on when the result side has room
    assign w_take     = r_valid && i_res_ready;
    assign o_in_stall = r_valid && !i_res_ready;
    assign w_load     = i_in_valid && !o_in_stall;

    always_comb begin
        n_valid = r_valid;
        if (w_load) begin
            n_valid = 1'b1;
        end else if (w_take) begin
            n_valid = 1'b0;
        end
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // item payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item.func      <= i_func;
            r_item.data_byte <= i_data_byte;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

`default_nettype wire

FILE: rtl/fmr_link_ctrl.sv
// link state, header parser, payload checksum and reply logic, one item per step
`timescale 1ns / 1ps
`default_nettype none

module fmr_link_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_step_en,
    input  fmr_pkg::t_in_item  i_item,
    input  wire                i_token_grant,
    output fmr_pkg::t_result   o_result
);

    typedef enum logic [2:0] {
        LS_BEGIN   = 3'd0,
        LS_RUNNING = 3'd1,
        LS_CLOSING = 3'd2,
        LS_CLOSED  = 3'd3,
        LS_FAILED  = 3'd4
    } t_link_state;

    // message type codes
    localparam logic [2:0] MT_BEGIN   = 3'd0;
    localparam logic [2:0] MT_DATA    = 3'd1;
    localparam logic [2:0] MT_TOKEN   = 3'd2;
    localparam logic [2:0] MT_END     = 3'd3;
    localparam logic [2:0] MT_CHECK   = 3'd4;
    localparam logic [2:0] MT_UNKNOWN = 3'd7;

    localparam logic [7:0] SPACE_CHAR = 8'h20;

    t_link_state r_link_state, n_link_state;
    logic        r_in_payload, n_in_payload;
    logic [31:0] r_byte_count, n_byte_count;
    logic [2:0]  r_msg_type, n_msg_type;
    logic [31:0] r_msg_length, n_msg_length;
    logic [31:0] r_expected_sum, n_expected_sum;
    logic [31:0] r_running_sum, n_running_sum;
    logic [31:0] r_word_shift, n_word_shift;
    logic [31:0] r_first_word, n_first_word;
    logic [31:0] r_job_ident, n_job_ident;
    logic [31:0] r_session_key, n_session_key;
    logic        r_space_seen, n_space_seen;
    logic [31:0] r_stored_keys [fmr_pkg::NUM_CHECK_KEYS];
    logic [31:0] n_stored_keys [fmr_pkg::NUM_CHECK_KEYS];

    fmr_pkg::t_result w_res;

    always_comb begin
        logic                          do_finish;
        logic [7:0]                    fin_byte;
        logic                          do_fail;
        logic [2:0]                    fail_code;
        logic [fmr_pkg::KEY_IDX_W-1:0] key_idx;
        logic [31:0]                   key;
        logic [31:0]                   kept;
        logic [31:0]                   rolled;

        n_link_state   = r_link_state;
        n_in_payload   = r_in_payload;
        n_byte_count   = r_byte_count;
        n_msg_type     = r_msg_type;
        n_msg_length   = r_msg_length;
        n_expected_sum = r_expected_sum;
        n_running_sum  = r_running_sum;
        n_word_shift   = r_word_shift;
        n_first_word   = r_first_word;
        n_job_ident    = r_job_ident;
        n_session_key  = r_session_key;
        n_space_seen   = r_space_seen;
        n_stored_keys  = r_stored_keys;

        do_finish = 1'b0;
        fin_byte  = 8'd0;
        do_fail   = 1'b0;
        fail_code = fmr_pkg::ERR_NONE;
        key       = 32'd0;
        kept      = 32'd0;
        rolled    = 32'd0;

        w_res.event_res    = fmr_pkg::EV_NONE;
        w_res.error_code   = fmr_pkg::ERR_NONE;
        w_res.payload_byte = 8'd0;
        w_res.job_id       = 32'd0;
        w_res.reply_word   = 32'd0;

        // close event and byte dispatch
        if (i_item.func == fmr_pkg::FUNC_CLOSE) begin
            if (r_link_state != LS_CLOSED) begin
                w_res.event_res = (r_link_state == LS_CLOSING) ? fmr_pkg::EV_CLOSE_OK
                                                               : fmr_pkg::EV_CLOSE_ABNORM;
                n_link_state = LS_CLOSED;
                n_in_payload = 1'b0;
                n_byte_count = 32'd0;
            end
        end else if (r_link_state == LS_CLOSED) begin
            w_res.event_res  = fmr_pkg::EV_ERROR;
            w_res.error_code = fmr_pkg::ERR_UNEXPECTED;
        end else if (r_link_state == LS_CLOSING) begin
            do_fail   = 1'b1;
            fail_code = fmr_pkg::ERR_UNEXPECTED;
        end else if (r_link_state != LS_FAILED) begin
            n_word_shift = {r_word_shift[23:0], i_item.data_byte};
            n_byte_count = r_byte_count + 32'd1;
            if (!r_in_payload) begin
                // header fields
                if (n_byte_count == 32'd4) begin
                    n_msg_type = (n_word_shift <= 32'(MT_CHECK)) ? n_word_shift[2:0]
                                                                 : MT_UNKNOWN;
                end else if (n_byte_count == 32'd8) begin
                    n_msg_length = n_word_shift;
                end else if (n_byte_count == fmr_pkg::HDR_BYTES) begin
                    n_expected_sum = n_word_shift;
                    n_byte_count   = 32'd0;
                    if (r_msg_type == MT_UNKNOWN) begin
                        do_fail   = 1'b1;
                        fail_code = fmr_pkg::ERR_UNKNOWN;
                    end else if (r_msg_type == MT_END) begin
                        n_link_state = LS_CLOSING;
                    end else if ((r_link_state == LS_BEGIN) != (r_msg_type == MT_BEGIN)) begin
                        do_fail   = 1'b1;
                        fail_code = fmr_pkg::ERR_UNEXPECTED;
                    end else if ((r_msg_type == MT_BEGIN || r_msg_type == MT_CHECK)
                                 && r_msg_length != 32'd8) begin
                        do_fail   = 1'b1;
                        fail_code = fmr_pkg::ERR_LENGTH;
                    end else begin
                        n_running_sum = 32'd0;
                        n_space_seen  = 1'b0;
                        n_word_shift  = 32'd0;
                        n_first_word  = 32'd0;
                        if (r_msg_length == 32'd0) begin
                            do_finish = 1'b1;
                        end else begin
                            n_in_payload = 1'b1;
                        end
                    end
                end
            end else begin
                // payload byte
                n_running_sum = fmr_pkg::sum_step(r_running_sum, i_item.data_byte);
                if (n_byte_count == 32'd4) begin
                    n_first_word = n_word_shift;
                end
                if (i_item.data_byte == SPACE_CHAR) begin
                    n_space_seen = 1'b1;
                end
                if (n_byte_count == r_msg_length) begin
                    do_finish = 1'b1;
                    fin_byte  = i_item.data_byte;
                end else if (r_msg_type == MT_DATA) begin
                    w_res.event_res    = fmr_pkg::EV_PAYLOAD;
                    w_res.payload_byte = i_item.data_byte;
                end
            end
        end

        // end of payload
        key_idx = n_first_word[fmr_pkg::KEY_IDX_W-1:0];
        if (do_finish) begin
            n_in_payload = 1'b0;
            n_byte_count = 32'd0;
            if (r_msg_type == MT_BEGIN) begin
                n_job_ident     = n_first_word;
                n_session_key   = n_word_shift;
                n_link_state    = LS_RUNNING;
                w_res.event_res = fmr_pkg::EV_BEGIN;
            end else if (n_running_sum != n_expected_sum) begin
                do_fail   = 1'b1;
                fail_code = fmr_pkg::ERR_CHECKSUM;
            end else if (r_msg_type == MT_DATA) begin
                w_res.event_res    = fmr_pkg::EV_LAST_GOOD;
                w_res.payload_byte = fin_byte;
            end else if (r_msg_type == MT_TOKEN) begin
                if (!n_space_seen) begin
                    do_fail   = 1'b1;
                    fail_code = fmr_pkg::ERR_LENGTH;
                end else begin
                    if (i_token_grant) begin
                        n_session_key = fmr_pkg::roll_key(r_session_key);
                    end
                    w_res.event_res  = fmr_pkg::EV_REPLY;
                    w_res.reply_word = n_session_key;
                end
            end else if (n_first_word >= 32'(fmr_pkg::NUM_CHECK_KEYS)) begin
                do_fail   = 1'b1;
                fail_code = fmr_pkg::ERR_CHECK_ID;
            end else begin
                // check message: remember the first key per id
                key           = n_word_shift ^ r_session_key;
                rolled        = fmr_pkg::roll_key(r_session_key);
                n_session_key = rolled;
                kept          = (r_stored_keys[key_idx] == 32'd0) ? key
                                                                  : r_stored_keys[key_idx];
                n_stored_keys[key_idx] = kept;
                w_res.event_res  = fmr_pkg::EV_REPLY;
                w_res.reply_word = kept ^ rolled;
            end
        end

        // link failure
        if (do_fail) begin
            w_res.event_res  = fmr_pkg::EV_ERROR;
            w_res.error_code = fail_code;
            n_link_state     = LS_FAILED;
            n_in_payload     = 1'b0;
            n_byte_count     = 32'd0;
        end

        w_res.job_id = n_job_ident;
    end

    // link state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_state   <= LS_BEGIN;
            r_in_payload   <= 1'b0;
            r_byte_count   <= 32'd0;
            r_msg_type     <= MT_BEGIN;
            r_msg_length   <= 32'd0;
            r_expected_sum <= 32'd0;
            r_running_sum  <= 32'd0;
            r_word_shift   <= 32'd0;
            r_first_word   <= 32'd0;
            r_job_ident    <= 32'd0;
            r_session_key  <= 32'd0;
            r_space_seen   <= 1'b0;
            for (int i = 0; i < fmr_pkg::NUM_CHECK_KEYS; i++) begin
                r_stored_keys[i] <= 32'd0;
            end
        end else if (i_step_en) begin
            r_link_state   <= n_link_state;
            r_in_payload   <= n_in_payload;
            r_byte_count   <= n_byte_count;
            r_msg_type     <= n_msg_type;
            r_msg_length   <= n_msg_length;
            r_expected_sum <= n_expected_sum;
            r_running_sum  <= n_running_sum;
            r_word_shift   <= n_word_shift;
            r_first_word   <= n_first_word;
            r_job_ident    <= n_job_ident;
            r_session_key  <= n_session_key;
            r_space_seen   <= n_space_seen;
            r_stored_keys  <= n_stored_keys;
        end
    end

    assign o_result = w_res;

    // header phase never counts past the header length
    a_hdr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_payload |-> r_byte_count < fmr_pkg::HDR_BYTES)
        else $error("header byte count out of range");

    // only begin, data, token and check messages carry a payload
    a_payload_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_payload |-> (r_msg_type == MT_BEGIN || r_msg_type == MT_DATA
                          || r_msg_type == MT_TOKEN || r_msg_type == MT_CHECK))
        else $error("payload phase with a type that has no payload");

    // a closed link never reopens
    a_closed_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_link_state == LS_CLOSED |=> r_link_state == LS_CLOSED)
        else $error("closed link left the closed state");

endmodule

`default_nettype wire

FILE: rtl/framed_message_receiver_core.sv
// top level of the framed message receiver: input stage, link logic and result register
//
// channel   direction  handshake                    payload
// in        input      i_in_valid / o_in_stall      i_func, i_data_byte
// out       output     o_out_valid / i_out_stall    o_event_res, o_error_code,
//                                                   o_payload_byte, o_job_id, o_reply_word
// cfg       input      i_cfg_valid / o_cfg_ready    i_cfg_token_grant
//
// one item per cycle sustained while the output is not stalled
// the item passes the input register, then one pass of the link logic into the result register
// synchronous active-low reset puts the link back to awaiting begin and clears stored keys
// an output stall holds the result register and fills the input register, then stalls the input
// the token grant register resets to 1 and is always ready for a write
`timescale 1ns / 1ps
`default_nettype none

module framed_message_receiver_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire         i_func,
    input  wire  [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [2:0]  o_event_res,
    output logic [2:0]  o_error_code,
    output logic [7:0]  o_payload_byte,
    output logic [31:0] o_job_id,
    output logic [31:0] o_reply_word,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire         i_cfg_token_grant
);

    logic              r_token_grant;
    logic              r_out_valid;
    logic              n_out_valid;
    fmr_pkg::t_result  r_result;
    fmr_pkg::t_result  w_result;
    fmr_pkg::t_in_item w_item;
    logic              w_item_valid;
    logic              w_res_ready;
    logic              w_step;

    // result register has room when empty or being drained
    assign w_res_ready = !r_out_valid || !i_out_stall;
    assign w_step      = w_item_valid && w_res_ready;

    fmr_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_data_byte  (i_data_byte),
        .i_res_ready  (w_res_ready),
        .o_item_valid (w_item_valid),
        .o_item       (w_item)
    );

    fmr_link_ctrl u_link_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step_en     (w_step),
        .i_item        (w_item),
        .i_token_grant (r_token_grant),
        .o_result      (w_result)
    );

    // configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_token_grant <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_token_grant <= i_cfg_token_grant;
        end
    end

    // result register valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_step) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_result <= w_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_event_res    = r_result.event_res;
    assign o_error_code   = r_result.error_code;
    assign o_payload_byte = r_result.payload_byte;
    assign o_job_id       = r_result.job_id;
    assign o_reply_word   = r_result.reply_word;

    // error code is set exactly on error events
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_event_res == fmr_pkg::EV_ERROR)
                         == (o_error_code != fmr_pkg::ERR_NONE)))
        else $error("error code does not match event");

    // reply word only carries data on reply events
    a_reply_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_event_res != fmr_pkg::EV_REPLY) |-> o_reply_word == 32'd0)
        else $error("reply word set outside a reply");

    // payload byte only carries data on payload and last-good events
    a_pbyte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_event_res != fmr_pkg::EV_PAYLOAD
         && o_event_res != fmr_pkg::EV_LAST_GOOD) |-> o_payload_byte == 8'd0)
        else $error("payload byte set outside a payload event");

    // a held input item with a full result register blocks new transfers
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_item_valid && r_out_valid && i_out_stall) |-> o_in_stall)
        else $error("input accepted while both stages are full");

endmodule

`default_nettype wire

FILE: verif/framed_message_receiver_checker.sv
// frame codes, checksum and key helpers, and the result checker for the framed message receiver
`timescale 1ns / 1ps

package fmr_frame_pkg;

    // message type codes as carried in the first header word
    localparam logic [2:0] MSG_BEGIN   = 3'd0;
    localparam logic [2:0] MSG_DATA    = 3'd1;
    localparam logic [2:0] MSG_TOKEN   = 3'd2;
    localparam logic [2:0] MSG_END     = 3'd3;
    localparam logic [2:0] MSG_CHECK   = 3'd4;
    localparam logic [2:0] MSG_UNKNOWN = 3'd7;

    // one step of the payload checksum
    function automatic logic [31:0] frame_sum_step(input logic [31:0] s, input logic [7:0] b);
        logic [31:0] mixed;
        mixed = s ^ 32'(b);
        return {mixed[30:0], 1'b0} | {31'd0, s[31]};
    endfunction

    // session key update
    function automatic logic [31:0] key_roll(input logic [31:0] k);
        return k ^ {k[28:0], 3'd0} ^ {7'd0, k[31:7]} ^ {k[14:0], 17'd0} ^ {27'd0, k[31:27]};
    endfunction

endpackage

module framed_message_receiver_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    input  wire         i_in_stall,
    input  wire         i_func,
    input  wire  [7:0]  i_data_byte,
    input  wire         i_out_valid,
    input  wire         i_out_stall,
    input  wire  [2:0]  i_event_res,
    input  wire  [2:0]  i_error_code,
    input  wire  [7:0]  i_payload_byte,
    input  wire  [31:0] i_job_id,
    input  wire  [31:0] i_reply_word,
    input  wire         i_cfg_valid,
    input  wire         i_cfg_ready,
    input  wire         i_cfg_token_grant,
    output int          o_fail_count,
    output int          o_pending
);

    import fmr_pkg::*;
    import fmr_frame_pkg::*;

    typedef enum logic [2:0] {
        LINK_WAIT_BEGIN,
        LINK_RUNNING,
        LINK_CLOSING,
        LINK_CLOSED,
        LINK_FAILED
    } t_link_state;

    // predicted link state
    t_link_state link_phase;
    logic        in_body;
    logic [31:0] byte_idx;
    logic [2:0]  frame_type;
    logic [31:0] frame_len;
    logic [31:0] sum_expected;
    logic [31:0] sum_running;
    logic [31:0] shift_word;
    logic [31:0] lead_word;
    logic [31:0] job_word;
    logic [31:0] key_word;
    logic [31:0] key_store [NUM_CHECK_KEYS];
    logic        space_found;
    logic        grant_on;

    t_result expected_results[$];
    int      mismatches = 0;

    task automatic clear_model();
        link_phase   = LINK_WAIT_BEGIN;
        in_body      = 1'b0;
        byte_idx     = '0;
        frame_type   = '0;
        frame_len    = '0;
        sum_expected = '0;
        sum_running  = '0;
        shift_word   = '0;
        lead_word    = '0;
        job_word     = '0;
        key_word     = '0;
        space_found  = 1'b0;
        grant_on     = 1'b1;
        for (int k = 0; k < NUM_CHECK_KEYS; k++) key_store[k] = '0;
    endtask

    // error ends the link
    task automatic go_failed(input logic [2:0] code, inout t_result r);
        r.event_res  = EV_ERROR;
        r.error_code = code;
        link_phase   = LINK_FAILED;
        in_body      = 1'b0;
        byte_idx     = '0;
    endtask

    // payload complete: act on the message
    task automatic close_payload(input logic [7:0] last, inout t_result r);
        logic [31:0] plain;
        in_body  = 1'b0;
        byte_idx = '0;
        if (frame_type == MSG_BEGIN) begin
            job_word    = lead_word;
            key_word    = shift_word;
            link_phase  = LINK_RUNNING;
            r.event_res = EV_BEGIN;
        end else if (sum_running != sum_expected) begin
            go_failed(ERR_CHECKSUM, r);
        end else if (frame_type == MSG_DATA) begin
            r.event_res    = EV_LAST_GOOD;
            r.payload_byte = last;
        end else if (frame_type == MSG_TOKEN) begin
            if (!space_found) begin
                go_failed(ERR_LENGTH, r);
            end else begin
                if (grant_on) key_word = key_roll(key_word);
                r.event_res  = EV_REPLY;
                r.reply_word = key_word;
            end
        end else if (lead_word >= NUM_CHECK_KEYS) begin
            go_failed(ERR_CHECK_ID, r);
        end else begin
            // first key per id is kept, reply is it under the new key
            plain    = shift_word ^ key_word;
            key_word = key_roll(key_word);
            if (key_store[lead_word[KEY_IDX_W-1:0]] == '0)
                key_store[lead_word[KEY_IDX_W-1:0]] = plain;
            r.event_res  = EV_REPLY;
            r.reply_word = key_store[lead_word[KEY_IDX_W-1:0]] ^ key_word;
        end
    endtask

    // header complete: decide on the message
    task automatic header_complete(inout t_result r);
        byte_idx = '0;
        if (frame_type == MSG_UNKNOWN) begin
            go_failed(ERR_UNKNOWN, r);
        end else if (frame_type == MSG_END) begin
            link_phase = LINK_CLOSING;
        end else if ((link_phase == LINK_WAIT_BEGIN) != (frame_type == MSG_BEGIN)) begin
            go_failed(ERR_UNEXPECTED, r);
        end else if ((frame_type == MSG_BEGIN || frame_type == MSG_CHECK)
                     && frame_len != 32'd8) begin
            go_failed(ERR_LENGTH, r);
        end else begin
            sum_running = '0;
            space_found = 1'b0;
            shift_word  = '0;
            lead_word   = '0;
            if (frame_len == '0) close_payload(8'd0, r);
            else in_body = 1'b1;
        end
    endtask

    // one byte on an open link
    task automatic absorb_byte(input logic [7:0] b, inout t_result r);
        shift_word = {shift_word[23:0], b};
        byte_idx   = byte_idx + 32'd1;
        if (!in_body) begin
            if (byte_idx == 32'd4)
                frame_type = (shift_word <= 32'(MSG_CHECK)) ? shift_word[2:0] : MSG_UNKNOWN;
            else if (byte_idx == 32'd8)
                frame_len = shift_word;
            else if (byte_idx == HDR_BYTES) begin
                sum_expected = shift_word;
                header_complete(r);
            end
        end else begin
            sum_running = frame_sum_step(sum_running, b);
            if (byte_idx == 32'd4) lead_word = shift_word;
            if (b == 8'h20) space_found = 1'b1;
            if (byte_idx == frame_len) begin
                close_payload(b, r);
            end else if (frame_type == MSG_DATA) begin
                r.event_res    = EV_PAYLOAD;
                r.payload_byte = b;
            end
        end
    endtask

    // expected result of one input transfer
    task automatic predict_step(input logic f, input logic [7:0] b, output t_result r);
        r = '0;
        if (f == FUNC_CLOSE) begin
            if (link_phase != LINK_CLOSED) begin
                r.event_res = (link_phase == LINK_CLOSING) ? EV_CLOSE_OK : EV_CLOSE_ABNORM;
                link_phase  = LINK_CLOSED;
                in_body     = 1'b0;
                byte_idx    = '0;
            end
        end else if (link_phase == LINK_CLOSED) begin
            r.event_res  = EV_ERROR;
            r.error_code = ERR_UNEXPECTED;
        end else if (link_phase == LINK_CLOSING) begin
            go_failed(ERR_UNEXPECTED, r);
        end else if (link_phase != LINK_FAILED) begin
            absorb_byte(b, r);
        end
        r.job_id = job_word;
    endtask

    task automatic match_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h actual %0h", name, want, got);
            mismatches++;
        end
    endtask

    initial clear_model();

    // watch the three channels at each rising edge
    always @(posedge i_clk) begin : watch
        t_result predicted;
        if (!i_rst_n) begin
            clear_model();
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) grant_on = i_cfg_token_grant;

            // result transfer against the oldest expectation
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with nothing expected: event %0d", i_event_res);
                    mismatches++;
                end else begin
                    predicted = expected_results.pop_front();
                    match_field("event_res", 32'(predicted.event_res), 32'(i_event_res));
                    match_field("error_code", 32'(predicted.error_code), 32'(i_error_code));
                    match_field("payload_byte", 32'(predicted.payload_byte),
                                32'(i_payload_byte));
                    match_field("job_id", predicted.job_id, i_job_id);
                    match_field("reply_word", predicted.reply_word, i_reply_word);
                end
            end

            // input transfer
            if (i_in_valid && !i_in_stall) begin
                predict_step(i_func, i_data_byte, predicted);
                expected_results.push_back(predicted);
            end
        end
        o_fail_count = mismatches;
        o_pending    = expected_results.size();
    end

endmodule

FILE: verif/framed_message_receiver_core_tb.sv
// stimulus and verdict for the framed message receiver core
`timescale 1ns / 1ps

module framed_message_receiver_core_tb;

    import fmr_pkg::*;
    import fmr_frame_pkg::*;

    localparam int RESET_CYCLES  = 5;
    localparam int PHASE_ITEMS   = 175;
    localparam int NOISE_ITEMS   = 24;
    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT   = 200000;

    // how the connection is ended or broken
    typedef enum int {
        TAIL_BAD_SUM,
        TAIL_EMPTY_BAD_SUM,
        TAIL_UNKNOWN_TYPE,
        TAIL_SECOND_BEGIN,
        TAIL_CHECK_LENGTH,
        TAIL_NO_SPACE,
        TAIL_EMPTY_TOKEN,
        TAIL_CHECK_ID,
        TAIL_END_CLOSE,
        TAIL_END_BYTE,
        TAIL_CLOSE_MIDWAY,
        TAIL_PRE_END,
        TAIL_PRE_DATA,
        TAIL_PRE_BEGIN_LENGTH
    } t_tail_kind;

    logic        i_clk             = 1'b0;
    logic        i_rst_n           = 1'b0;
    logic        i_in_valid        = 1'b0;
    logic        i_func            = 1'b0;
    logic [7:0]  i_data_byte       = 8'd0;
    logic        i_out_stall       = 1'b0;
    logic        i_cfg_valid       = 1'b0;
    logic        i_cfg_token_grant = 1'b1;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [2:0]  o_event_res;
    logic [2:0]  o_error_code;
    logic [7:0]  o_payload_byte;
    logic [31:0] o_job_id;
    logic [31:0] o_reply_word;
    logic        o_cfg_ready;

    int fail_count;
    int results_pending;
    int cycle_count   = 0;
    int sent_items    = 0;
    int in_idle_pct   = 0;
    int out_stall_pct = 0;

    logic [7:0] frame_body[$];

    framed_message_receiver_core uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_func            (i_func),
        .i_data_byte       (i_data_byte),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_event_res       (o_event_res),
        .o_error_code      (o_error_code),
        .o_payload_byte    (o_payload_byte),
        .o_job_id          (o_job_id),
        .o_reply_word      (o_reply_word),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_token_grant (i_cfg_token_grant)
    );

    framed_message_receiver_checker result_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_stall        (o_in_stall),
        .i_func            (i_func),
        .i_data_byte       (i_data_byte),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .i_event_res       (o_event_res),
        .i_error_code      (o_error_code),
        .i_payload_byte    (o_payload_byte),
        .i_job_id          (o_job_id),
        .i_reply_word      (o_reply_word),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_token_grant (i_cfg_token_grant),
        .o_fail_count      (fail_count),
        .o_pending         (results_pending)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // receiver stalls at random
    always @(negedge i_clk) i_out_stall <= ($urandom_range(0, 99) < out_stall_pct);

    // one input transfer, with random idle cycles ahead of it
    task automatic send_item(input logic func, input logic [7:0] value);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_func      <= func;
        i_data_byte <= value;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sent_items++;
        @(negedge i_clk);
    endtask

    // 32-bit word, most significant byte first
    task automatic send_word(input logic [31:0] word);
        for (int k = 3; k >= 0; k--) send_item(FUNC_BYTE, word[8*k +: 8]);
    endtask

    task automatic fill_body(input int len);
        frame_body.delete();
        repeat (len) frame_body.push_back(8'($urandom_range(0, 255)));
    endtask

    // lead word followed by a random word
    task automatic fill_pair_body(input logic [31:0] lead);
        frame_body.delete();
        for (int k = 3; k >= 0; k--) frame_body.push_back(lead[8*k +: 8]);
        repeat (4) frame_body.push_back(8'($urandom_range(0, 255)));
    endtask

    function automatic logic [31:0] body_checksum();
        logic [31:0] sum;
        sum = 32'd0;
        foreach (frame_body[k]) sum = frame_sum_step(sum, frame_body[k]);
        return sum;
    endfunction

    // header with the body's length, then the body
    task automatic send_frame(input logic [31:0] type_word, input logic [31:0] sum_word);
        send_word(type_word);
        send_word(32'(frame_body.size()));
        send_word(sum_word);
        foreach (frame_body[k]) send_item(FUNC_BYTE, frame_body[k]);
    endtask

    // well-formed message with random content
    task automatic send_random_message();
        int pick;
        int len;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            // mostly short data payloads, now and then empty or long
            case ($urandom_range(0, 9))
                0: len = 0;
                9: len = $urandom_range(13, 40);
                default: len = $urandom_range(1, 12);
            endcase
            fill_body(len);
            send_frame(32'(MSG_DATA), body_checksum());
        end else if (pick < 72) begin
            len = $urandom_range(1, 12);
            fill_body(len);
            frame_body[$urandom_range(0, len - 1)] = 8'h20;
            send_frame(32'(MSG_TOKEN), body_checksum());
        end else begin
            fill_pair_body($urandom_range(0, NUM_CHECK_KEYS - 1));
            send_frame(32'(MSG_CHECK), body_checksum());
        end
    endtask

    // sequence that ends or breaks the connection
    task automatic run_tail(input t_tail_kind kind);
        logic [31:0] word;
        int          len;
        int          cut;
        case (kind)
            TAIL_BAD_SUM: begin
                fill_body($urandom_range(1, 8));
                send_frame(32'(MSG_DATA), body_checksum() ^ (32'd1 << $urandom_range(0, 31)));
            end
            TAIL_EMPTY_BAD_SUM: begin
                fill_body(0);
                send_frame(32'(MSG_DATA), $urandom | 32'd1);
            end
            TAIL_UNKNOWN_TYPE: begin
                word = $urandom;
                if (word <= 32'(MSG_CHECK)) word = word + 32'd5;
                send_word(word);
                send_word($urandom);
                send_word($urandom);
            end
            TAIL_SECOND_BEGIN: begin
                fill_body(8);
                send_frame(32'(MSG_BEGIN), $urandom);
            end
            TAIL_CHECK_LENGTH, TAIL_PRE_BEGIN_LENGTH: begin
                // any length but eight
                len = $urandom_range(0, 15);
                if (len >= 8) len++;
                fill_body(len);
                send_frame(32'((kind == TAIL_CHECK_LENGTH) ? MSG_CHECK : MSG_BEGIN),
                           body_checksum());
            end
            TAIL_NO_SPACE: begin
                fill_body($urandom_range(1, 10));
                foreach (frame_body[k]) if (frame_body[k] == 8'h20) frame_body[k] = 8'h21;
                send_frame(32'(MSG_TOKEN), body_checksum());
            end
            TAIL_EMPTY_TOKEN: begin
                fill_body(0);
                send_frame(32'(MSG_TOKEN), 32'd0);
            end
            TAIL_CHECK_ID: begin
                word = $urandom;
                if (word < NUM_CHECK_KEYS) word = word + NUM_CHECK_KEYS;
                fill_pair_body(word);
                send_frame(32'(MSG_CHECK), body_checksum());
            end
            TAIL_END_CLOSE, TAIL_END_BYTE, TAIL_PRE_END: begin
                // end header with arbitrary length and checksum
                send_word(32'(MSG_END));
                send_word(($urandom_range(0, 1) == 0) ? 32'd0 : $urandom);
                send_word($urandom);
                send_item((kind == TAIL_END_BYTE) ? FUNC_BYTE : FUNC_CLOSE,
                          8'($urandom_range(0, 255)));
            end
            TAIL_CLOSE_MIDWAY: begin
                len = $urandom_range(2, 16);
                fill_body(len);
                cut = $urandom_range(0, len - 1);
                send_word(32'(MSG_DATA));
                send_word(len);
                send_word(body_checksum());
                for (int k = 0; k < cut; k++) send_item(FUNC_BYTE, frame_body[k]);
                send_item(FUNC_CLOSE, 8'($urandom_range(0, 255)));
            end
            default: begin
                fill_body($urandom_range(0, 6));
                send_frame(32'(MSG_DATA), body_checksum());
            end
        endcase
    endtask

    // drop valid and wait until every result has come back
    task automatic wait_results_done();
        i_in_valid <= 1'b0;
        while (results_pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // quiet the link, set the token grant, then random well-formed traffic
    task automatic run_random_phase(input int sender_idle, input int receiver_idle,
                                    input logic grant);
        int start;
        wait_results_done();
        i_cfg_valid       <= 1'b1;
        i_cfg_token_grant <= grant;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid   <= 1'b0;
        in_idle_pct   = sender_idle;
        out_stall_pct = receiver_idle;
        start         = sent_items;
        while (sent_items - start < PHASE_ITEMS) send_random_message();
    endtask

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, results_pending);
        $display("framed_message_receiver_core verification failed");
        $finish;
    end

    initial begin
        t_tail_kind tail;
        // one way of ending the connection per run, rarely one before begin
        if ($urandom_range(0, 9) == 0)
            tail = t_tail_kind'(TAIL_PRE_END + $urandom_range(0, 2));
        else
            tail = t_tail_kind'($urandom_range(0, TAIL_CLOSE_MIDWAY));

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        if (tail >= TAIL_PRE_END) run_tail(tail);

        // opening: begin with all-ones job id, then an empty data payload
        fill_pair_body(32'hFFFF_FFFF);
        send_frame(32'(MSG_BEGIN), 32'd0);
        fill_body(0);
        send_frame(32'(MSG_DATA), 32'd0);

        run_random_phase(14, 60, 1'b0);
        run_random_phase(60, 14, 1'b1);
        run_random_phase(0, 0, 1'($urandom_range(0, 1)));

        if (tail < TAIL_PRE_END) run_tail(tail);

        // bytes and closes on the failed or closed link
        repeat (NOISE_ITEMS)
            send_item(($urandom_range(0, 3) == 0) ? FUNC_CLOSE : FUNC_BYTE,
                      8'($urandom_range(0, 255)));

        wait_results_done();
        $display("%0d input transfers over three idle mixes, link ended by %s, %0d mismatches",
                 sent_items, tail.name(), fail_count);
        if (fail_count == 0)
            $display("framed_message_receiver_core verification clean");
        else
            $display("framed_message_receiver_core verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/fmr_pkg.sv
rtl/fmr_in_stage.sv
rtl/fmr_link_ctrl.sv
rtl/framed_message_receiver_core.sv
verif/framed_message_receiver_checker.sv
verif/framed_message_receiver_core_tb.sv
